// ===== hw/rtl/rtsf_pkg.sv =====
// Shared widths, reset values, register indexes and beat types for the touch sample filter.
`default_nettype none

package rtsf_pkg;

    localparam int RAW_W               = 12;
    localparam int PRESS_W             = 13;
    localparam int SCR_X_W             = 8;
    localparam int SCR_Y_W             = 9;
    localparam int SIZE_W              = 12;
    localparam int PROD_W              = RAW_W + SIZE_W;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 13;
    localparam int DIV_STEPS_PER_STAGE = 2;

    localparam int DEF_SCREEN_WIDTH  = 240;
    localparam int DEF_SCREEN_HEIGHT = 320;

    localparam logic [RAW_W-1:0]   FULL_SCALE   = 12'hFFF;
    localparam logic [RAW_W-1:0]   GLITCH_LIMIT = 12'd2048;

    localparam logic [PRESS_W-1:0] RST_THRESHOLD = 13'd400;
    localparam logic [RAW_W-1:0]   RST_X_MIN     = 12'd260;
    localparam logic [RAW_W-1:0]   RST_X_MAX     = 12'd3760;
    localparam logic [RAW_W-1:0]   RST_Y_MIN     = 12'd260;
    localparam logic [RAW_W-1:0]   RST_Y_MAX     = 12'd3660;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_MIRROR_X  = 3'd1,
        CFG_MIRROR_Y  = 3'd2,
        CFG_X_MIN     = 3'd3,
        CFG_X_MAX     = 3'd4,
        CFG_Y_MIN     = 3'd5,
        CFG_Y_MAX     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [PROD_W-1:0] dvd;
        logic [RAW_W-1:0]  den;
        logic              sat;
        logic              zero;
    } axis_job_t;

    typedef struct packed {
        logic               touched;
        logic [PRESS_W-1:0] pressure;
        logic [RAW_W-1:0]   raw_x;
        logic [RAW_W-1:0]   raw_y;
    } frame_meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtsf_if.sv =====
// Frame, result and configuration channel interfaces.
`default_nettype none

interface rtsf_frame_if;
    import rtsf_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] pressure_first;
    logic [RAW_W-1:0] pressure_second;
    logic [RAW_W-1:0] x_reading_a;
    logic [RAW_W-1:0] x_reading_b;
    logic [RAW_W-1:0] x_reading_c;
    logic [RAW_W-1:0] y_reading_a;
    logic [RAW_W-1:0] y_reading_b;
    logic [RAW_W-1:0] y_reading_c;

    modport source (
        output valid, pressure_first, pressure_second,
               x_reading_a, x_reading_b, x_reading_c,
               y_reading_a, y_reading_b, y_reading_c,
        input  ready
    );
    modport sink (
        input  valid, pressure_first, pressure_second,
               x_reading_a, x_reading_b, x_reading_c,
               y_reading_a, y_reading_b, y_reading_c,
        output ready
    );
endinterface

interface rtsf_result_if;
    import rtsf_pkg::*;
    logic               valid;
    logic               ready;
    logic               touched;
    logic [PRESS_W-1:0] pressure;
    logic [RAW_W-1:0]   raw_x;
    logic [RAW_W-1:0]   raw_y;
    logic [SCR_X_W-1:0] screen_x;
    logic [SCR_Y_W-1:0] screen_y;

    modport source (
        output valid, touched, pressure, raw_x, raw_y, screen_x, screen_y,
        input  ready
    );
    modport sink (
        input  valid, touched, pressure, raw_x, raw_y, screen_x, screen_y,
        output ready
    );
endinterface

interface rtsf_cfg_if;
    import rtsf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/resistive_touch_sample_filter.sv =====
// Top level of the resistive touch sample filter: pressure gate, pair filter, calibration.
// Ten register stages: four front stages, then six divider stages of two quotient bits each.
// Throughput: one frame per cycle unless the result side stalls.
// The divider depth sets the latency.
// Reset: clears all stage valid bits and loads the configuration defaults.
`default_nettype none

module resistive_touch_sample_filter #(
    parameter int SCREEN_WIDTH  = rtsf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rtsf_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rtsf_frame_if.sink    frame,
    rtsf_result_if.source result,
    rtsf_cfg_if.sink      cfg
);
    import rtsf_pkg::*;

    localparam logic [SIZE_W-1:0] SIZE_X = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_Y = SIZE_W'(SCREEN_HEIGHT);

    function automatic logic [RAW_W-1:0] absdiff(input logic [RAW_W-1:0] p,
                                                 input logic [RAW_W-1:0] q);
        return (p > q) ? (p - q) : (q - p);
    endfunction

    function automatic logic [RAW_W-1:0] pair_mean(
        input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b, input logic [RAW_W-1:0] c,
        input logic [RAW_W-1:0] dab, input logic [RAW_W-1:0] dca,
        input logic [RAW_W-1:0] dbc);
        logic [RAW_W:0] sum;
        priority if (dab <= dca && dab <= dbc) sum = {1'b0, a} + {1'b0, b};
        else if (dca <= dab && dca <= dbc)     sum = {1'b0, a} + {1'b0, c};
        else                                   sum = {1'b0, b} + {1'b0, c};
        return sum[RAW_W:1];
    endfunction

    // configuration registers
    logic [PRESS_W-1:0] thr_reg;
    logic               mirror_x_reg;
    logic               mirror_y_reg;
    logic [RAW_W-1:0]   x_min_reg;
    logic [RAW_W-1:0]   x_max_reg;
    logic [RAW_W-1:0]   y_min_reg;
    logic [RAW_W-1:0]   y_max_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= RST_THRESHOLD;
            mirror_x_reg <= 1'b0;
            mirror_y_reg <= 1'b0;
            x_min_reg    <= RST_X_MIN;
            x_max_reg    <= RST_X_MAX;
            y_min_reg    <= RST_Y_MIN;
            y_max_reg    <= RST_Y_MAX;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_THRESHOLD: thr_reg      <= cfg.data[PRESS_W-1:0];
                CFG_MIRROR_X:  mirror_x_reg <= cfg.data[0];
                CFG_MIRROR_Y:  mirror_y_reg <= cfg.data[0];
                CFG_X_MIN:     x_min_reg    <= cfg.data[RAW_W-1:0];
                CFG_X_MAX:     x_max_reg    <= cfg.data[RAW_W-1:0];
                CFG_Y_MIN:     y_min_reg    <= cfg.data[RAW_W-1:0];
                CFG_Y_MAX:     y_max_reg    <= cfg.data[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake chain
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic s1_take, s2_take, s3_take, s4_take;
    logic div_in_ready;

    assign s4_take     = !s4_v_reg || div_in_ready;
    assign s3_take     = !s3_v_reg || s4_take;
    assign s2_take     = !s2_v_reg || s3_take;
    assign s1_take     = !s1_v_reg || s2_take;
    assign frame.ready = s1_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_take) s1_v_reg <= frame.valid;
            if (s2_take) s2_v_reg <= s1_v_reg;
            if (s3_take) s3_v_reg <= s2_v_reg;
            if (s4_take) s4_v_reg <= s3_v_reg;
        end
    end

    // stage 1: pressure, touch gate, pairwise distances
    logic [RAW_W-1:0]   z1_clean;
    logic [PRESS_W-1:0] s1_press_next;
    logic               s1_touched_reg;
    logic [PRESS_W-1:0] s1_press_reg;
    logic [RAW_W-1:0]   s1_x_reg  [3];
    logic [RAW_W-1:0]   s1_y_reg  [3];
    logic [RAW_W-1:0]   s1_xd_reg [3];
    logic [RAW_W-1:0]   s1_yd_reg [3];

    assign z1_clean      = (frame.pressure_first >= GLITCH_LIMIT) ? '0 : frame.pressure_first;
    assign s1_press_next = PRESS_W'(FULL_SCALE) + PRESS_W'(z1_clean)
                         - PRESS_W'(frame.pressure_second);

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_press_reg   <= s1_press_next;
            s1_touched_reg <= (s1_press_next >= thr_reg);
            s1_x_reg[0]    <= frame.x_reading_a;
            s1_x_reg[1]    <= frame.x_reading_b;
            s1_x_reg[2]    <= frame.x_reading_c;
            s1_y_reg[0]    <= frame.y_reading_a;
            s1_y_reg[1]    <= frame.y_reading_b;
            s1_y_reg[2]    <= frame.y_reading_c;
            s1_xd_reg[0]   <= absdiff(frame.x_reading_a, frame.x_reading_b);
            s1_xd_reg[1]   <= absdiff(frame.x_reading_c, frame.x_reading_a);
            s1_xd_reg[2]   <= absdiff(frame.x_reading_b, frame.x_reading_c);
            s1_yd_reg[0]   <= absdiff(frame.y_reading_a, frame.y_reading_b);
            s1_yd_reg[1]   <= absdiff(frame.y_reading_c, frame.y_reading_a);
            s1_yd_reg[2]   <= absdiff(frame.y_reading_b, frame.y_reading_c);
        end
    end

    // stage 2: closest pair mean, mirror, zero untouched frames
    logic [RAW_W-1:0] x_mean, y_mean, x_dir, y_dir;
    frame_meta_t      s2_meta_next;
    frame_meta_t      s2_meta_reg;

    assign x_mean = pair_mean(s1_x_reg[0], s1_x_reg[1], s1_x_reg[2],
                              s1_xd_reg[0], s1_xd_reg[1], s1_xd_reg[2]);
    assign y_mean = pair_mean(s1_y_reg[0], s1_y_reg[1], s1_y_reg[2],
                              s1_yd_reg[0], s1_yd_reg[1], s1_yd_reg[2]);
    assign x_dir  = mirror_x_reg ? (FULL_SCALE - x_mean) : x_mean;
    assign y_dir  = mirror_y_reg ? (FULL_SCALE - y_mean) : y_mean;

    always_comb
    begin
        s2_meta_next.touched  = s1_touched_reg;
        s2_meta_next.pressure = s1_touched_reg ? s1_press_reg : '0;
        s2_meta_next.raw_x    = s1_touched_reg ? x_dir : '0;
        s2_meta_next.raw_y    = s1_touched_reg ? y_dir : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_take) s2_meta_reg <= s2_meta_next;
    end

    // stage 3: calibration offsets and span
    logic [RAW_W-1:0] s3_num_x_reg, s3_num_y_reg;
    axis_job_t        s3_job_x_reg, s3_job_y_reg;
    frame_meta_t      s3_meta_reg;

    always_ff @(posedge clk)
    begin
        if (s3_take)
        begin
            s3_meta_reg       <= s2_meta_reg;
            s3_num_x_reg      <= s2_meta_reg.raw_x - x_min_reg;
            s3_num_y_reg      <= s2_meta_reg.raw_y - y_min_reg;
            s3_job_x_reg.dvd  <= '0;
            s3_job_x_reg.den  <= x_max_reg - x_min_reg;
            s3_job_x_reg.zero <= (x_max_reg <= x_min_reg) || (s2_meta_reg.raw_x <= x_min_reg);
            s3_job_x_reg.sat  <= (s2_meta_reg.raw_x >= x_max_reg);
            s3_job_y_reg.dvd  <= '0;
            s3_job_y_reg.den  <= y_max_reg - y_min_reg;
            s3_job_y_reg.zero <= (y_max_reg <= y_min_reg) || (s2_meta_reg.raw_y <= y_min_reg);
            s3_job_y_reg.sat  <= (s2_meta_reg.raw_y >= y_max_reg);
        end
    end

    // stage 4: scale by screen size
    axis_job_t   s4_job_x_reg, s4_job_y_reg;
    frame_meta_t s4_meta_reg;

    always_ff @(posedge clk)
    begin
        if (s4_take)
        begin
            s4_meta_reg       <= s3_meta_reg;
            s4_job_x_reg.dvd  <= PROD_W'(s3_num_x_reg) * PROD_W'(SIZE_X);
            s4_job_x_reg.den  <= s3_job_x_reg.den;
            s4_job_x_reg.sat  <= s3_job_x_reg.sat;
            s4_job_x_reg.zero <= s3_job_x_reg.zero;
            s4_job_y_reg.dvd  <= PROD_W'(s3_num_y_reg) * PROD_W'(SIZE_Y);
            s4_job_y_reg.den  <= s3_job_y_reg.den;
            s4_job_y_reg.sat  <= s3_job_y_reg.sat;
            s4_job_y_reg.zero <= s3_job_y_reg.zero;
        end
    end

    // stages 5 and on: division and saturation
    logic [RAW_W-1:0] scr_x, scr_y;
    frame_meta_t      out_meta;

    rtsf_div #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .in_ready  (div_in_ready),
        .job_x     (s4_job_x_reg),
        .job_y     (s4_job_y_reg),
        .in_meta   (s4_meta_reg),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .scr_x     (scr_x),
        .scr_y     (scr_y),
        .out_meta  (out_meta)
    );

    assign result.touched  = out_meta.touched;
    assign result.pressure = out_meta.pressure;
    assign result.raw_x    = out_meta.raw_x;
    assign result.raw_y    = out_meta.raw_y;
    assign result.screen_x = scr_x[SCR_X_W-1:0];
    assign result.screen_y = scr_y[SCR_Y_W-1:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready |=> s1_v_reg)
        else $error("accepted frame beat did not enter the first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.touched |->
            result.pressure == '0 && result.raw_x == '0 && result.raw_y == '0 &&
            result.screen_x == '0 && result.screen_y == '0)
        else $error("untouched result beat carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.touched |-> result.pressure >= thr_reg)
        else $error("touched result beat below pressure threshold");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.touched && result.raw_x <= x_min_reg |-> result.screen_x == '0)
        else $error("screen x nonzero for raw x at or below calibration minimum");

endmodule

`default_nettype wire

// ===== hw/rtl/rtsf_div.sv =====
// Pipelined restoring divider mapping both axes to screen coordinates.
`default_nettype none

module rtsf_div #(
    parameter int SCREEN_WIDTH  = rtsf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rtsf_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire rtsf_pkg::axis_job_t       job_x,
    input  wire rtsf_pkg::axis_job_t       job_y,
    input  wire rtsf_pkg::frame_meta_t     in_meta,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rtsf_pkg::RAW_W-1:0]     scr_x,
    output logic [rtsf_pkg::RAW_W-1:0]     scr_y,
    output rtsf_pkg::frame_meta_t          out_meta
);
    import rtsf_pkg::*;

    localparam int NSTG = RAW_W / DIV_STEPS_PER_STAGE;
    localparam logic [RAW_W-1:0] SIZE_X = RAW_W'(SCREEN_WIDTH);
    localparam logic [RAW_W-1:0] SIZE_Y = RAW_W'(SCREEN_HEIGHT);

    typedef struct packed {
        logic [RAW_W-1:0] rem;
        logic [RAW_W-1:0] quo;
        logic [RAW_W-1:0] low;
        logic [RAW_W-1:0] den;
        logic             sat;
        logic             zero;
    } div_lane_t;

    function automatic div_lane_t lane_start(input axis_job_t j);
        div_lane_t l;
        l.rem  = j.dvd[PROD_W-1:RAW_W];
        l.low  = j.dvd[RAW_W-1:0];
        l.quo  = '0;
        l.den  = j.den;
        l.sat  = j.sat;
        l.zero = j.zero;
        return l;
    endfunction

    function automatic div_lane_t lane_steps(input div_lane_t l);
        div_lane_t        r;
        logic [RAW_W:0]   trial;
        r = l;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            trial = {r.rem, r.low[RAW_W-1]};
            if (trial >= {1'b0, r.den}) begin
                r.rem = RAW_W'(trial - {1'b0, r.den});
                r.quo = {r.quo[RAW_W-2:0], 1'b1};
            end
            else begin
                r.rem = trial[RAW_W-1:0];
                r.quo = {r.quo[RAW_W-2:0], 1'b0};
            end
            r.low = {r.low[RAW_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_lane_t lane_finish(input div_lane_t l, input logic [RAW_W-1:0] size);
        div_lane_t r;
        r = l;
        priority if (l.zero) r.quo = '0;
        else if (l.sat)      r.quo = size;
        else                 r.quo = l.quo;
        return r;
    endfunction

    div_lane_t   lx_reg   [NSTG];
    div_lane_t   ly_reg   [NSTG];
    frame_meta_t meta_reg [NSTG];
    div_lane_t   lx_next  [NSTG];
    div_lane_t   ly_next  [NSTG];
    logic [NSTG-1:0] v_reg;
    logic [NSTG:0]   take;

    assign take[NSTG] = out_ready;
    assign in_ready   = take[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        div_lane_t   sx;
        div_lane_t   sy;
        logic        prev_v;
        frame_meta_t prev_meta;

        assign take[k] = !v_reg[k] || take[k+1];

        if (k == 0) begin : g_first
            assign sx        = lane_steps(lane_start(job_x));
            assign sy        = lane_steps(lane_start(job_y));
            assign prev_v    = in_valid;
            assign prev_meta = in_meta;
        end
        else begin : g_mid
            assign sx        = lane_steps(lx_reg[k-1]);
            assign sy        = lane_steps(ly_reg[k-1]);
            assign prev_v    = v_reg[k-1];
            assign prev_meta = meta_reg[k-1];
        end

        if (k == NSTG - 1) begin : g_last
            assign lx_next[k] = lane_finish(sx, SIZE_X);
            assign ly_next[k] = lane_finish(sy, SIZE_Y);
        end
        else begin : g_pass
            assign lx_next[k] = sx;
            assign ly_next[k] = sy;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (take[k])
            begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (take[k])
            begin
                lx_reg[k]   <= lx_next[k];
                ly_reg[k]   <= ly_next[k];
                meta_reg[k] <= prev_meta;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign scr_x     = lx_reg[NSTG-1].quo;
    assign scr_y     = ly_reg[NSTG-1].quo;
    assign out_meta  = meta_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== test/resistive_touch_sample_filter_tb.sv =====
// Self-checking bench for the touch sample filter: frames in, calibrated touch results checked.
`default_nettype none

module resistive_touch_sample_filter_tb;
    import rtsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PANEL_WIDTH  = DEF_SCREEN_WIDTH;
    localparam int PANEL_HEIGHT = DEF_SCREEN_HEIGHT;
    localparam int PIPE_LATENCY = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0] pressure_first;
        logic [RAW_W-1:0] pressure_second;
        logic [RAW_W-1:0] x_reading_a;
        logic [RAW_W-1:0] x_reading_b;
        logic [RAW_W-1:0] x_reading_c;
        logic [RAW_W-1:0] y_reading_a;
        logic [RAW_W-1:0] y_reading_b;
        logic [RAW_W-1:0] y_reading_c;
    } frame_t;

    typedef struct packed {
        logic               touched;
        logic [PRESS_W-1:0] pressure;
        logic [RAW_W-1:0]   raw_x;
        logic [RAW_W-1:0]   raw_y;
        logic [SCR_X_W-1:0] screen_x;
        logic [SCR_Y_W-1:0] screen_y;
    } touch_result_t;

    class touch_scoreboard;
        touch_result_t      expected_q[$];
        int unsigned        fault_count;
        int unsigned        frames_seen;
        int unsigned        touches_seen;
        int unsigned        results_seen;
        logic [PRESS_W-1:0] threshold;
        logic               flip_x;
        logic               flip_y;
        logic [RAW_W-1:0]   x_lo;
        logic [RAW_W-1:0]   x_hi;
        logic [RAW_W-1:0]   y_lo;
        logic [RAW_W-1:0]   y_hi;

        function new();
            threshold = RST_THRESHOLD;
            flip_x    = 1'b0;
            flip_y    = 1'b0;
            x_lo      = RST_X_MIN;
            x_hi      = RST_X_MAX;
            y_lo      = RST_Y_MIN;
            y_hi      = RST_Y_MAX;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold = data;
                CFG_MIRROR_X:  flip_x    = data[0];
                CFG_MIRROR_Y:  flip_y    = data[0];
                CFG_X_MIN:     x_lo      = data[RAW_W-1:0];
                CFG_X_MAX:     x_hi      = data[RAW_W-1:0];
                CFG_Y_MIN:     y_lo      = data[RAW_W-1:0];
                CFG_Y_MAX:     y_hi      = data[RAW_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pair_mean(int unsigned a, int unsigned b, int unsigned c);
            int unsigned dab;
            int unsigned dca;
            int unsigned dbc;
            dab = (a > b) ? a - b : b - a;
            dca = (c > a) ? c - a : a - c;
            dbc = (b > c) ? b - c : c - b;
            if (dab <= dca && dab <= dbc)
                return (a + b) >> 1;
            if (dca <= dab && dca <= dbc)
                return (a + c) >> 1;
            return (b + c) >> 1;
        endfunction

        function int unsigned to_screen(int unsigned raw, int unsigned lo, int unsigned hi,
                                        int unsigned span);
            longint unsigned q;
            if (hi <= lo || raw <= lo)
                return 0;
            q = (longint'(raw - lo) * longint'(span)) / longint'(hi - lo);
            if (q > span)
                q = span;
            return int'(q);
        endfunction

        function void note_frame(frame_t f);
            touch_result_t r;
            int unsigned   z1;
            int unsigned   z;
            int unsigned   x;
            int unsigned   y;
            r = '0;
            frames_seen++;
            z1 = (f.pressure_first >= GLITCH_LIMIT) ? 0 : int'(f.pressure_first);
            z  = 4095 + z1 - int'(f.pressure_second);
            if (z >= threshold)
            begin
                x = pair_mean(f.x_reading_a, f.x_reading_b, f.x_reading_c);
                y = pair_mean(f.y_reading_a, f.y_reading_b, f.y_reading_c);
                if (flip_x)
                    x = 4095 - x;
                if (flip_y)
                    y = 4095 - y;
                r.touched  = 1'b1;
                r.pressure = PRESS_W'(z);
                r.raw_x    = RAW_W'(x);
                r.raw_y    = RAW_W'(y);
                r.screen_x = SCR_X_W'(to_screen(x, x_lo, x_hi, PANEL_WIDTH));
                r.screen_y = SCR_Y_W'(to_screen(y, y_lo, y_hi, PANEL_HEIGHT));
                touches_seen++;
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                fault_count++;
            end
        endfunction

        function void check_result(touch_result_t got);
            touch_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with no frame pending, got %h", $time, got);
                fault_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("touched", want.touched, got.touched);
            compare_field("pressure", want.pressure, got.pressure);
            compare_field("raw_x", want.raw_x, got.raw_x);
            compare_field("raw_y", want.raw_y, got.raw_y);
            compare_field("screen_x", want.screen_x, got.screen_x);
            compare_field("screen_y", want.screen_y, got.screen_y);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   stall_pct;
    int   hold_left;
    int   settings_applied;

    touch_scoreboard sb = new();

    rtsf_frame_if  frame_ch();
    rtsf_result_if result_ch();
    rtsf_cfg_if    cfg_ch();

    resistive_touch_sample_filter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("%0t: run timed out waiting on a handshake", $time);
        $display("[resistive_touch_sample_filter] ERROR");
        $finish;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{touched:  result_ch.touched,
                              pressure: result_ch.pressure,
                              raw_x:    result_ch.raw_x,
                              raw_y:    result_ch.raw_y,
                              screen_x: result_ch.screen_x,
                              screen_y: result_ch.screen_y});
    end

    function automatic frame_t mk(int z1, int z2, int xa, int xb, int xc,
                                  int ya, int yb, int yc);
        frame_t f;
        f.pressure_first  = RAW_W'(z1);
        f.pressure_second = RAW_W'(z2);
        f.x_reading_a     = RAW_W'(xa);
        f.x_reading_b     = RAW_W'(xb);
        f.x_reading_c     = RAW_W'(xc);
        f.y_reading_a     = RAW_W'(ya);
        f.y_reading_b     = RAW_W'(yb);
        f.y_reading_c     = RAW_W'(yc);
        return f;
    endfunction

    task automatic make_axis(output logic [RAW_W-1:0] a, output logic [RAW_W-1:0] b,
                             output logic [RAW_W-1:0] c);
        int v[3];
        int base;
        int mode;
        mode = $urandom_range(3);
        base = $urandom_range(4095);
        for (int k = 0; k < 3; k++)
        begin
            v[k] = base + int'($urandom_range(40)) - 20;
            if (v[k] < 0)
                v[k] = 0;
            if (v[k] > 4095)
                v[k] = 4095;
            if (mode == 0)
                v[k] = $urandom_range(4095);
        end
        if (mode == 1)
            v[$urandom_range(2)] = $urandom_range(4095);
        a = RAW_W'(v[0]);
        b = RAW_W'(v[1]);
        c = RAW_W'(v[2]);
    endtask

    task automatic make_frame(output frame_t f);
        if ($urandom_range(7) == 0)
            f.pressure_first = RAW_W'($urandom_range(4095, 2048));
        else
            f.pressure_first = RAW_W'($urandom_range(2047));
        f.pressure_second = RAW_W'($urandom_range(4095));
        make_axis(f.x_reading_a, f.x_reading_b, f.x_reading_c);
        make_axis(f.y_reading_a, f.y_reading_b, f.y_reading_c);
    endtask

    task automatic send_frame(frame_t f, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid           <= 1'b1;
        frame_ch.pressure_first  <= f.pressure_first;
        frame_ch.pressure_second <= f.pressure_second;
        frame_ch.x_reading_a     <= f.x_reading_a;
        frame_ch.x_reading_b     <= f.x_reading_b;
        frame_ch.x_reading_c     <= f.x_reading_c;
        frame_ch.y_reading_a     <= f.y_reading_a;
        frame_ch.y_reading_b     <= f.y_reading_b;
        frame_ch.y_reading_c     <= f.y_reading_c;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        sb.note_frame(f);
    endtask

    task automatic end_burst();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int recv_pct);
        frame_t f;
        stall_pct = recv_pct;
        repeat (count)
        begin
            make_frame(f);
            send_frame(f, idle_pct);
        end
        end_burst();
        drain();
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(int th, int mx, int my, int xlo, int xhi, int ylo, int yhi);
        program_reg(CFG_THRESHOLD, CFG_DATA_W'(th));
        program_reg(CFG_MIRROR_X, CFG_DATA_W'(mx));
        program_reg(CFG_MIRROR_Y, CFG_DATA_W'(my));
        program_reg(CFG_X_MIN, CFG_DATA_W'(xlo));
        program_reg(CFG_X_MAX, CFG_DATA_W'(xhi));
        program_reg(CFG_Y_MIN, CFG_DATA_W'(ylo));
        program_reg(CFG_Y_MAX, CFG_DATA_W'(yhi));
        settings_applied++;
    endtask

    task automatic apply_random_settings();
        int th;
        int lo[2];
        int hi[2];
        int tmp;
        th = ($urandom_range(3) == 0) ? $urandom_range(6142) : $urandom_range(1500);
        for (int k = 0; k < 2; k++)
        begin
            lo[k] = $urandom_range(1500);
            hi[k] = $urandom_range(4095, 2500);
            if ($urandom_range(4) == 0)
            begin
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
            // set the unused top data bit now and then; only 12 bits are kept
            lo[k] += $urandom_range(1) << RAW_W;
            hi[k] += $urandom_range(1) << RAW_W;
        end
        apply_settings(th, $urandom_range(8191), $urandom_range(8191),
                       lo[0], hi[0], lo[1], hi[1]);
    endtask

    task automatic run_directed();
        frame_t dir_q[$];
        stall_pct = 0;
        dir_q.push_back(mk(0, 4095, 2000, 2000, 2000, 2000, 2000, 2000));
        dir_q.push_back(mk(0, 3696, 1500, 1500, 1500, 1500, 1500, 1500));
        dir_q.push_back(mk(0, 3695, 1500, 1500, 1500, 1500, 1500, 1500));
        dir_q.push_back(mk(2047, 0, 4095, 4095, 4095, 4095, 4095, 4095));
        dir_q.push_back(mk(2048, 0, 0, 0, 0, 0, 0, 0));
        dir_q.push_back(mk(4095, 4095, 3000, 3000, 3000, 3000, 3000, 3000));
        dir_q.push_back(mk(1000, 500, 260, 260, 260, 260, 260, 260));
        dir_q.push_back(mk(1000, 500, 261, 261, 261, 261, 261, 261));
        dir_q.push_back(mk(1000, 500, 3760, 3760, 3760, 3660, 3660, 3660));
        dir_q.push_back(mk(1000, 500, 100, 110, 90, 500, 500, 500));
        dir_q.push_back(mk(1000, 500, 100, 120, 110, 3000, 3020, 3010));
        dir_q.push_back(mk(1000, 500, 0, 2000, 2001, 4095, 10, 11));
        dir_q.push_back(mk(1000, 500, 100, 110, 120, 1, 2, 4000));
        dir_q.push_back(mk(1000, 500, 4094, 4095, 0, 2500, 2600, 2550));
        dir_q.push_back(mk('h555, 'hAAA, 'hAAA, 'hAAA, 'h555, 'h555, 'h555, 'hAAA));
        dir_q.push_back(mk('h7FF, 'hFFF, 'h555, 'h555, 'hAAA, 'hAAA, 'hAAA, 'h555));
        dir_q.push_back(mk('h2AA, 'h555, 'hFFF, 'h000, 'h800, 'h7FF, 'h800, 'h000));
        foreach (dir_q[k])
            send_frame(dir_q[k], 0);
        end_burst();
        drain();
    endtask

    initial
    begin
        stall_pct        = 0;
        hold_left        = 0;
        settings_applied = 0;
        rst_n                    <= 1'b0;
        frame_ch.valid           <= 1'b0;
        frame_ch.pressure_first  <= '0;
        frame_ch.pressure_second <= '0;
        frame_ch.x_reading_a     <= '0;
        frame_ch.x_reading_b     <= '0;
        frame_ch.x_reading_c     <= '0;
        frame_ch.y_reading_a     <= '0;
        frame_ch.y_reading_b     <= '0;
        frame_ch.y_reading_c     <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= CFG_THRESHOLD;
        cfg_ch.data              <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(80, 0, 0);

        apply_settings(0, 1, 1, 0, 4095, 0, 4095);
        program_reg(CFG_SPARE, 13'h1FFF);
        run_phase(120, 82, 0);

        apply_settings(3000, 0, 1, 4095, 0, 2000, 2000);
        run_phase(100, 0, 82);

        apply_settings(6142, 1, 0, 1000, 1001, 4094, 4095);
        run_phase(40, 33, 33);

        for (int k = 0; k < 4; k++)
        begin
            apply_random_settings();
            case (k)
                0:
                begin
                    // hold the result side off while frames keep coming
                    hold_left = HOLD_CYCLES;
                    run_phase(85, 0, 0);
                end
                1: run_phase(85, 82, 0);
                2: run_phase(85, 0, 82);
                default: run_phase(85, 33, 33);
            endcase
        end

        drain();
        repeat (PIPE_LATENCY * 2) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.fault_count++;
        end
        $display("Sent %0d frames (%0d above threshold) under %0d register settings,",
                 sb.frames_seen, sb.touches_seen, settings_applied);
        $display("with back-pressure, idle gaps and a long output hold; %0d results checked.",
                 sb.results_seen);
        if (sb.fault_count == 0)
            $display("[resistive_touch_sample_filter] OK");
        else
            $display("[resistive_touch_sample_filter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
